FILE: src/odta_pkg.sv
// Shared constants, codes and item types for the outline depth annotator.
package odta_pkg;

	// Capacity of one outline; index ports are sized from it
	localparam int MAX_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = IDX_W + 1;

	// Depth field width and the number of levels it can name
	localparam int DEPTH_W        = 4;
	localparam int LVL_SPAN       = 2 ** DEPTH_W;
	localparam int DEF_MAX_LEVELS = 16;

	// Saturation point for entry and sibling counts
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_ENTRIES - 1);

	// Parent index of a top-level entry
	localparam logic signed [IDX_W:0] NO_PARENT = '1;

	// Queue depths
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 4;

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_JUMP = 2'd1,
		ERR_FULL = 2'd2
	} err_t;

	// Classified entry, front to back
	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic               push;
		logic               fin;
		logic [IDX_W-1:0]   gidx;
		err_t               err;
	} cmd_t;

	// Annotated entry, back to result queue
	typedef struct packed {
		logic [IDX_W-1:0]        gidx;
		logic [IDX_W-1:0]        lidx;
		logic signed [IDX_W:0]   parent;
		logic [DEPTH_W-1:0]      depth;
		logic                    has_children;
		logic                    local_last;
		logic                    global_last;
		err_t                    err;
		logic                    last_of_run;
	} res_t;

endpackage

FILE: src/odta_fifo.sv
// Small register queue used between front and back and on the result side.
module odta_fifo #(
	parameter type item_t = logic,
	parameter int  DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wdata,
	input  logic  rd,
	output item_t rdata,
	output logic  full,
	output logic  empty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = PW + 1;

	item_t           slots_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign rdata = slots_q[rptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + PW'(1);
			if (rd) rptr_q <= rptr_q + PW'(1);
			if (wr && !rd)      count_q <= count_q + CW'(1);
			else if (rd && !wr) count_q <= count_q - CW'(1);
		end
	end

	// storage, no reset
	always_ff @(posedge clk) begin
		if (wr) slots_q[wptr_q] <= wdata;
	end

endmodule

FILE: src/odta_front.sv
// Front end: takes entries, repairs depth, numbers them and flags errors.
module odta_front #(
	parameter int MAX_LEVELS = odta_pkg::DEF_MAX_LEVELS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [odta_pkg::DEPTH_W-1:0] depth,
	input  logic                         final_entry,
	input  logic                         cmd_full,
	output logic                         full,
	output logic                         cmd_wr,
	output odta_pkg::cmd_t               cmd
);
	import odta_pkg::*;

	localparam int STACK_LVLS = (MAX_LEVELS < LVL_SPAN) ? MAX_LEVELS : LVL_SPAN;
	localparam logic [DEPTH_W-1:0] LVL_TOP = DEPTH_W'(STACK_LVLS - 1);

	logic [DEPTH_W-1:0] level_q;
	logic [CNT_W-1:0]   seen_q;

	logic [DEPTH_W:0]   level_inc;
	logic [DEPTH_W-1:0] d_fix;
	logic [CNT_W-1:0]   seen_nxt;
	err_t               err;
	logic               accept;

	assign full   = cmd_full;
	assign accept = push && !cmd_full;
	assign cmd_wr = accept;

	// depth repair, capacity check and numbering
	always_comb begin
		level_inc = {1'b0, level_q} + (DEPTH_W + 1)'(1);
		d_fix     = depth;
		err       = ERR_NONE;
		seen_nxt  = seen_q;
		if ({1'b0, depth} > level_inc) begin
			d_fix = level_inc[DEPTH_W-1:0];
			err   = ERR_JUMP;
		end
		if (d_fix > LVL_TOP) begin
			d_fix = LVL_TOP;
			err   = ERR_JUMP;
		end
		if (seen_q >= CNT_W'(MAX_ENTRIES)) begin
			cmd.gidx = IDX_TOP;
			err      = ERR_FULL;
		end else begin
			cmd.gidx = seen_q[IDX_W-1:0];
			seen_nxt = seen_q + CNT_W'(1);
		end
		cmd.depth = d_fix;
		cmd.push  = (d_fix > level_q);
		cmd.fin   = final_entry;
		cmd.err   = err;
	end

	// current level and entry count; a final entry starts a fresh outline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			seen_q  <= '0;
		end else if (accept) begin
			if (final_entry) begin
				level_q <= '0;
				seen_q  <= '0;
			end else begin
				level_q <= d_fix;
				seen_q  <= seen_nxt;
			end
		end
	end

endmodule

FILE: src/odta_back.sv
// Back end: sibling and ancestor stacks, held entry and result forming.
module odta_back #(
	parameter int MAX_LEVELS = odta_pkg::DEF_MAX_LEVELS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_avail,
	input  odta_pkg::cmd_t cmd,
	output logic           cmd_rd,
	input  logic           res_room,
	output logic           res_wr,
	output odta_pkg::res_t res
);
	import odta_pkg::*;

	localparam int STACK_LVLS = (MAX_LEVELS < LVL_SPAN) ? MAX_LEVELS : LVL_SPAN;
	localparam int SIW        = $clog2(STACK_LVLS);

	logic [IDX_W-1:0]      sib_q [STACK_LVLS];
	logic signed [IDX_W:0] anc_q [STACK_LVLS];

	// entry waiting for its successor
	logic                  held_v_q;
	logic [DEPTH_W-1:0]    held_depth_q;
	logic [IDX_W-1:0]      held_g_q;
	logic [IDX_W-1:0]      held_l_q;
	logic signed [IDX_W:0] held_p_q;
	err_t                  held_err_q;

	// final result parked behind the held one
	logic                  pend_v_q;
	res_t                  pend_q;

	logic                  take;
	logic [SIW-1:0]        lvl;
	logic [IDX_W-1:0]      local_idx;
	logic [IDX_W-1:0]      sib_nxt;
	logic signed [IDX_W:0] parent;
	res_t                  held_res;
	res_t                  fin_res;

	assign take   = cmd_avail && res_room && !pend_v_q;
	assign cmd_rd = take;
	assign lvl    = cmd.depth[SIW-1:0];

	// stack lookup; a push starts a new sibling run under the held entry
	always_comb begin
		local_idx = cmd.push ? '0 : sib_q[lvl];
		sib_nxt   = (local_idx < IDX_TOP) ? local_idx + IDX_W'(1) : local_idx;
		if (cmd.push)      parent = held_v_q ? $signed({1'b0, held_g_q}) : NO_PARENT;
		else if (lvl == '0) parent = NO_PARENT;
		else                parent = anc_q[lvl];
	end

	// the two results an entry can finish
	always_comb begin
		held_res.gidx         = held_g_q;
		held_res.lidx         = held_l_q;
		held_res.parent       = held_p_q;
		held_res.depth        = held_depth_q;
		held_res.has_children = (cmd.depth > held_depth_q);
		held_res.local_last   = (cmd.depth < held_depth_q);
		held_res.global_last  = 1'b0;
		held_res.err          = held_err_q;
		held_res.last_of_run  = !cmd.fin;

		fin_res.gidx          = cmd.gidx;
		fin_res.lidx          = local_idx;
		fin_res.parent        = parent;
		fin_res.depth         = cmd.depth;
		fin_res.has_children  = 1'b0;
		fin_res.local_last    = 1'b1;
		fin_res.global_last   = 1'b1;
		fin_res.err           = cmd.err;
		fin_res.last_of_run   = 1'b1;
	end

	// result select: parked result first, then held, then final
	always_comb begin
		res    = held_res;
		res_wr = 1'b0;
		if (pend_v_q) begin
			res    = pend_q;
			res_wr = res_room;
		end else if (take) begin
			if (held_v_q) begin
				res    = held_res;
				res_wr = 1'b1;
			end else if (cmd.fin) begin
				res    = fin_res;
				res_wr = 1'b1;
			end
		end
	end

	// control state and sibling counters; deeper levels restart on their next push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			for (int i = 0; i < STACK_LVLS; i++) sib_q[i] <= '0;
		end else begin
			if (pend_v_q && res_room) pend_v_q <= 1'b0;
			if (take) begin
				if (cmd.fin) begin
					held_v_q <= 1'b0;
					sib_q[0] <= '0;
					if (held_v_q) pend_v_q <= 1'b1;
				end else begin
					sib_q[lvl] <= sib_nxt;
					held_v_q   <= 1'b1;
				end
			end
		end
	end

	// payload: ancestors, held entry, parked result
	always_ff @(posedge clk) begin
		if (take) begin
			if (cmd.push) anc_q[lvl] <= parent;
			if (cmd.fin) begin
				pend_q <= fin_res;
			end else begin
				held_depth_q <= cmd.depth;
				held_g_q     <= cmd.gidx;
				held_l_q     <= local_idx;
				held_p_q     <= parent;
				held_err_q   <= cmd.err;
			end
		end
	end

endmodule

FILE: src/outline_depth_tree_annotator.sv
// Top level of the outline depth annotator: front, command queue, back, result queue.
//
//  channel  | handshake     | fields
//  ---------+---------------+--------------------------------------------------
//  entries  | push / full   | depth, final_entry
//  results  | empty / pop   | global_index, local_index, parent_index,
//           |               | entry_depth, has_children, is_local_last,
//           |               | is_global_last, error_code, last_of_run
//
// One entry per cycle is taken while full is low; the front is combinational into
// the command queue, the back reads the entry from that queue and writes the result
// queue, and a result is registered in the result queue before it can be popped.
// A final entry that also closes a held entry gives two results, the held one first,
// then the parked one, as the back writes one result a cycle while the queue has room.
// Reset clears the level, entry count, held entry and queues; no sweep is needed.
// A stalled result side fills the result queue, then the command queue, then full rises.
module outline_depth_tree_annotator #(
	parameter int MAX_LEVELS = odta_pkg::DEF_MAX_LEVELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [odta_pkg::DEPTH_W-1:0]  depth,
	input  logic                          final_entry,
	output logic                          empty,
	input  logic                          pop,
	output logic [odta_pkg::IDX_W-1:0]    global_index,
	output logic [odta_pkg::IDX_W-1:0]    local_index,
	output logic signed [odta_pkg::IDX_W:0] parent_index,
	output logic [odta_pkg::DEPTH_W-1:0]  entry_depth,
	output logic                          has_children,
	output logic                          is_local_last,
	output logic                          is_global_last,
	output logic [1:0]                    error_code,
	output logic                          last_of_run
);
	import odta_pkg::*;

	logic cmd_wr;
	logic cmd_full;
	logic cmd_empty;
	logic cmd_rd;
	cmd_t cmd_in;
	cmd_t cmd_out;
	logic res_wr;
	logic res_full;
	res_t res_in;
	res_t res_out;

	odta_front #(.MAX_LEVELS(MAX_LEVELS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.depth       (depth),
		.final_entry (final_entry),
		.cmd_full    (cmd_full),
		.full        (full),
		.cmd_wr      (cmd_wr),
		.cmd         (cmd_in)
	);

	odta_fifo #(.item_t(cmd_t), .DEPTH(CMD_DEPTH)) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_wr),
		.wdata  (cmd_in),
		.rd     (cmd_rd),
		.rdata  (cmd_out),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	odta_back #(.MAX_LEVELS(MAX_LEVELS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (!cmd_empty),
		.cmd       (cmd_out),
		.cmd_rd    (cmd_rd),
		.res_room  (!res_full),
		.res_wr    (res_wr),
		.res       (res_in)
	);

	odta_fifo #(.item_t(res_t), .DEPTH(RES_DEPTH)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_wr),
		.wdata  (res_in),
		.rd     (pop && !empty),
		.rdata  (res_out),
		.full   (res_full),
		.empty  (empty)
	);

	// result fields out
	assign global_index   = res_out.gidx;
	assign local_index    = res_out.lidx;
	assign parent_index   = res_out.parent;
	assign entry_depth    = res_out.depth;
	assign has_children   = res_out.has_children;
	assign is_local_last  = res_out.local_last;
	assign is_global_last = res_out.global_last;
	assign error_code     = res_out.err;
	assign last_of_run    = res_out.last_of_run;

endmodule

FILE: src/odta_checker.sv
// Port-level checks on the annotator's results, bound to the top level.
module odta_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           empty,
	input  logic                           pop,
	input  logic [odta_pkg::IDX_W-1:0]     global_index,
	input  logic signed [odta_pkg::IDX_W:0] parent_index,
	input  logic [odta_pkg::DEPTH_W-1:0]   entry_depth,
	input  logic                           has_children,
	input  logic                           is_local_last,
	input  logic                           is_global_last,
	input  logic [1:0]                     error_code,
	input  logic                           last_of_run
);
	import odta_pkg::*;

	// the final entry closes its run, has no children and ends its sibling run
	a_final_shape: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_global_last |-> last_of_run && is_local_last && !has_children)
		else $error("final entry result malformed");

	// a parent always comes earlier in the list unless indices have saturated
	a_parent_before: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && error_code != ERR_FULL |->
		$signed(parent_index) < $signed({1'b0, global_index}))
		else $error("parent index not before entry");

	// top-level entries have no parent
	a_top_parent: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && entry_depth == '0 |-> parent_index == NO_PARENT)
		else $error("top-level entry has a parent");

	// a waiting result holds until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(global_index) && $stable(last_of_run))
		else $error("waiting result changed");

endmodule

bind outline_depth_tree_annotator odta_checker u_odta_checker (.*);
